FILE: rtl/core/wsdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

    localparam int MAX_LEN_W = 63;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [2:0] LEN16_LAST = 3'd1;
    localparam logic [2:0] LEN64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    localparam logic BYTE_KIND_HEADER  = 1'b0;
    localparam logic BYTE_KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       resync;
    } in_item_t;

    typedef struct packed {
        logic                 byte_kind;
        logic [7:0]           out_byte;
        logic                 fin_flag;
        logic [3:0]           frame_opcode;
        logic                 is_masked;
        logic [MAX_LEN_W-1:0] payload_length;
        logic                 header_done;
        logic                 frame_end;
        logic                 oversize;
    } out_item_t;

    typedef struct packed {
        logic        byte_kind;
        logic [7:0]  raw_byte;
        logic [7:0]  key_byte;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        is_masked;
        logic [63:0] length;
        logic        header_done;
        logic        frame_end;
    } front_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/wsdf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wsdf_front
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire wsdf_pkg::in_item_t     in_item,
    output wsdf_pkg::front_item_t       item
);

    typedef enum logic [2:0]
    {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [2:0]  count_reg, count_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic [63:0] length_reg, length_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [1:0]  lane_reg, lane_next;
    logic        kind, done, fend;
    logic [7:0]  key_byte;
    logic [7:0]  b;
    logic        length_complete;

    assign b = in_item.data_byte;

    always_comb
    begin
        case (lane_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        fin_next        = fin_reg;
        opcode_next     = opcode_reg;
        mask_next       = mask_reg;
        length_next     = length_reg;
        key_next        = key_reg;
        remaining_next  = remaining_reg;
        lane_next       = lane_reg;
        kind            = wsdf_pkg::BYTE_KIND_HEADER;
        done            = 1'b0;
        fend            = 1'b0;
        length_complete = 1'b0;
        phase_eff       = in_item.resync ? PH_FIRST : phase_reg;

        unique case (phase_eff)
            PH_SECOND:
            begin
                mask_next  = b[7];
                count_next = '0;
                if (b[6:0] == wsdf_pkg::LEN7_EXT16)
                begin
                    length_next = '0;
                    phase_next  = PH_LEN16;
                end
                else if (b[6:0] == wsdf_pkg::LEN7_EXT64)
                begin
                    length_next = '0;
                    phase_next  = PH_LEN64;
                end
                else
                begin
                    length_next     = {57'd0, b[6:0]};
                    length_complete = 1'b1;
                end
            end
            PH_LEN16, PH_LEN64:
            begin
                length_next = {length_reg[55:0], b};
                count_next  = count_reg + 3'd1;
                if ((phase_eff == PH_LEN16 && count_reg == wsdf_pkg::LEN16_LAST) ||
                    (phase_eff == PH_LEN64 && count_reg == wsdf_pkg::LEN64_LAST))
                begin
                    length_complete = 1'b1;
                end
            end
            PH_KEY:
            begin
                key_next   = {key_reg[23:0], b};
                count_next = count_reg + 3'd1;
                if (count_reg == wsdf_pkg::KEY_LAST)
                begin
                    done = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                kind      = wsdf_pkg::BYTE_KIND_PAYLOAD;
                lane_next = lane_reg + 2'd1;
                if (remaining_reg[63:1] == '0)
                begin
                    remaining_next = '0;
                    fend           = 1'b1;
                    phase_next     = PH_FIRST;
                end
                else
                begin
                    remaining_next = remaining_reg - 64'd1;
                end
            end
            default:
            begin
                fin_next       = b[7];
                opcode_next    = b[3:0];
                mask_next      = 1'b0;
                length_next    = '0;
                key_next       = '0;
                lane_next      = '0;
                remaining_next = '0;
                count_next     = '0;
                phase_next     = PH_SECOND;
            end
        endcase

        if (length_complete)
        begin
            count_next = '0;
            if (mask_next)
            begin
                phase_next = PH_KEY;
            end
            else
            begin
                done = 1'b1;
            end
        end

        if (done)
        begin
            remaining_next = length_next;
            lane_next      = '0;
            count_next     = '0;
            if (length_next == '0)
            begin
                phase_next = PH_FIRST;
                fend       = 1'b1;
            end
            else
            begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    always_comb
    begin
        item.byte_kind    = kind;
        item.raw_byte     = b;
        item.key_byte     = key_byte;
        item.fin_flag     = fin_next;
        item.frame_opcode = opcode_next;
        item.is_masked    = mask_next;
        item.length       = length_next;
        item.header_done  = done;
        item.frame_end    = fend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            length_reg    <= '0;
            key_reg       <= '0;
            remaining_reg <= '0;
            lane_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            length_reg    <= length_next;
            key_reg       <= key_next;
            remaining_reg <= remaining_next;
            lane_reg      <= lane_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wsdf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module wsdf_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire wsdf_pkg::front_item_t push_item,
    input  wire logic                  pop,
    output wsdf_pkg::front_item_t      head_item,
    output logic                       full,
    output logic                       empty
);

    wsdf_pkg::front_item_t entry_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/wsdf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wsdf_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_enable,
    input  wire logic [wsdf_pkg::MAX_LEN_W-1:0]      cfg_write_data,
    input  wire logic                                head_present,
    input  wire wsdf_pkg::front_item_t               head_item,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output wsdf_pkg::out_item_t                      out_data
);

    logic [wsdf_pkg::MAX_LEN_W-1:0] max_len_reg;
    logic                           valid_reg;
    wsdf_pkg::out_item_t            data_reg, data_next;
    logic                           too_long;

    assign pop       = head_present && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign too_long = head_item.length[63] ||
                      (head_item.length[wsdf_pkg::MAX_LEN_W-1:0] > max_len_reg);

    always_comb
    begin
        data_next.byte_kind      = head_item.byte_kind;
        if (head_item.byte_kind != wsdf_pkg::BYTE_KIND_PAYLOAD)
        begin
            data_next.out_byte = 8'd0;
        end
        else if (head_item.is_masked)
        begin
            data_next.out_byte = head_item.raw_byte ^ head_item.key_byte;
        end
        else
        begin
            data_next.out_byte = head_item.raw_byte;
        end
        data_next.fin_flag       = head_item.fin_flag;
        data_next.frame_opcode   = head_item.frame_opcode;
        data_next.is_masked      = head_item.is_masked;
        data_next.payload_length = head_item.length[wsdf_pkg::MAX_LEN_W-1:0];
        data_next.header_done    = head_item.header_done;
        data_next.frame_end      = head_item.frame_end;
        data_next.oversize       = (head_item.header_done || head_item.byte_kind) && too_long;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            max_len_reg <= '1;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
            if (cfg_write_enable)
            begin
                max_len_reg <= cfg_write_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/websocket_frame_deframer_top.sv
// Channel   Direction  Payload                Transfer when
// in        input      wsdf_pkg::in_item_t    in_valid && !in_stall
// out       output     wsdf_pkg::out_item_t   out_valid && !out_stall
// cfg       input      max length, 63 b       cfg_write_enable
//
// One byte is accepted per cycle while in_stall is low, and each gives one result.
// The parser state updates in the cycle of the transfer, a two-entry queue
// holds the classified byte, and the output register adds the unmasking
// and the length check. Reset clears the parser and sets the maximum to all
// ones. A stall on the output fills the queue, after which in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire wsdf_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output wsdf_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_write_enable,
    input  wire logic [wsdf_pkg::MAX_LEN_W-1:0] cfg_write_data
);

    wsdf_pkg::front_item_t front_item;
    wsdf_pkg::front_item_t head_item;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  pop;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    wsdf_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_data),
        .item    (front_item)
    );

    wsdf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (full),
        .empty     (empty)
    );

    wsdf_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .head_present     (!empty),
        .head_item        (head_item),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 215;

    localparam logic [2:0] PARSE_FIRST   = 3'd0;
    localparam logic [2:0] PARSE_SECOND  = 3'd1;
    localparam logic [2:0] PARSE_LEN16   = 3'd2;
    localparam logic [2:0] PARSE_LEN64   = 3'd3;
    localparam logic [2:0] PARSE_KEY     = 3'd4;
    localparam logic [2:0] PARSE_PAYLOAD = 3'd5;

    typedef struct packed {
        wsdf_pkg::in_item_t  item;
        logic                typed;
        wsdf_pkg::out_item_t want;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    wsdf_pkg::in_item_t             in_data;
    logic                           out_valid;
    logic                           out_stall;
    wsdf_pkg::out_item_t            out_data;
    logic                           cfg_write_enable;
    logic [wsdf_pkg::MAX_LEN_W-1:0] cfg_write_data;

    logic [2:0]                     ps_phase;
    logic [2:0]                     ps_count;
    logic                           ps_fin;
    logic [3:0]                     ps_opcode;
    logic                           ps_mask;
    logic [63:0]                    ps_len;
    logic [31:0]                    ps_key;
    logic [63:0]                    ps_remaining;
    logic [1:0]                     ps_lane;
    logic [wsdf_pkg::MAX_LEN_W-1:0] max_len;

    wsdf_pkg::out_item_t            deframed_q[$];
    wsdf_pkg::in_item_t             stream_q[$];
    stim_row_t                      directed_rows[25];
    int                             errors;
    int                             phase_items;
    int                             idle_cycles;
    logic                           hold_req;
    logic                           calm;

    websocket_frame_deframer_top DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .out_data         (out_data),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic logic finish_header();
        ps_remaining = ps_len;
        ps_lane = '0;
        ps_count = '0;
        if (ps_len == 64'd0)
        begin
            ps_phase = PARSE_FIRST;
            return 1'b1;
        end
        ps_phase = PARSE_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic logic after_length(output logic done);
        ps_count = '0;
        if (ps_mask)
        begin
            ps_phase = PARSE_KEY;
            done = 1'b0;
            return 1'b0;
        end
        done = 1'b1;
        return finish_header();
    endfunction

    function automatic wsdf_pkg::out_item_t deframe_byte(input wsdf_pkg::in_item_t it);
        wsdf_pkg::out_item_t r;
        logic [2:0]          ph;
        logic [2:0]          last;
        logic [7:0]          b;
        logic [7:0]          ob;
        logic                kind;
        logic                done;
        logic                fend;
        logic                hit;
        b = it.data_byte;
        ph = ps_phase;
        ob = '0;
        kind = wsdf_pkg::BYTE_KIND_HEADER;
        done = 1'b0;
        fend = 1'b0;
        if (it.resync || ph > PARSE_PAYLOAD)
            ph = PARSE_FIRST;
        case (ph)
            PARSE_FIRST:
            begin
                ps_fin = b[7];
                ps_opcode = b[3:0];
                ps_mask = 1'b0;
                ps_len = '0;
                ps_key = '0;
                ps_lane = '0;
                ps_remaining = '0;
                ps_count = '0;
                ps_phase = PARSE_SECOND;
            end
            PARSE_SECOND:
            begin
                ps_mask = b[7];
                ps_count = '0;
                ps_len = '0;
                if (b[6:0] == wsdf_pkg::LEN7_EXT16)
                    ps_phase = PARSE_LEN16;
                else if (b[6:0] == wsdf_pkg::LEN7_EXT64)
                    ps_phase = PARSE_LEN64;
                else
                begin
                    ps_len = {57'd0, b[6:0]};
                    fend = after_length(done);
                end
            end
            PARSE_LEN16, PARSE_LEN64:
            begin
                last = (ph == PARSE_LEN16) ? wsdf_pkg::LEN16_LAST : wsdf_pkg::LEN64_LAST;
                ps_len = {ps_len[55:0], b};
                hit = (ps_count == last);
                ps_count = ps_count + 3'd1;
                if (hit)
                    fend = after_length(done);
            end
            PARSE_KEY:
            begin
                ps_key = {ps_key[23:0], b};
                hit = (ps_count == wsdf_pkg::KEY_LAST);
                ps_count = ps_count + 3'd1;
                if (hit)
                begin
                    done = 1'b1;
                    fend = finish_header();
                end
            end
            default:
            begin
                kind = wsdf_pkg::BYTE_KIND_PAYLOAD;
                ob = ps_mask ? (b ^ ps_key[8 * (3 - ps_lane) +: 8]) : b;
                ps_lane = ps_lane + 2'd1;
                if (ps_remaining <= 64'd1)
                begin
                    ps_remaining = '0;
                    fend = 1'b1;
                    ps_phase = PARSE_FIRST;
                end
                else
                    ps_remaining = ps_remaining - 64'd1;
            end
        endcase
        r.byte_kind = kind;
        r.out_byte = ob;
        r.fin_flag = ps_fin;
        r.frame_opcode = ps_opcode;
        r.is_masked = ps_mask;
        r.payload_length = ps_len[wsdf_pkg::MAX_LEN_W-1:0];
        r.header_done = done;
        r.frame_end = fend;
        r.oversize = (done || kind) && (ps_len > {1'b0, max_len});
        return r;
    endfunction

    function automatic wsdf_pkg::out_item_t header_result(logic fin, logic [3:0] opcode,
                                                          logic masked,
                                                          logic [wsdf_pkg::MAX_LEN_W-1:0] len,
                                                          logic hd, logic fe, logic ov);
        wsdf_pkg::out_item_t r;
        r = '0;
        r.byte_kind = wsdf_pkg::BYTE_KIND_HEADER;
        r.fin_flag = fin;
        r.frame_opcode = opcode;
        r.is_masked = masked;
        r.payload_length = len;
        r.header_done = hd;
        r.frame_end = fe;
        r.oversize = ov;
        return r;
    endfunction

    task automatic send_byte(input wsdf_pkg::in_item_t it, input logic typed,
                             input wsdf_pkg::out_item_t want);
        int                  gap;
        int                  p;
        wsdf_pkg::out_item_t predicted;
        p = $urandom_range(0, 99);
        if (calm || p < 60)
            gap = 0;
        else if (p < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = deframe_byte(it);
        deframed_q.push_back(typed ? want : predicted);
        phase_items++;
        @(negedge clk);
    endtask

    task automatic build_frame(input logic lead_resync, output logic cut);
        wsdf_pkg::in_item_t it;
        logic [63:0]        len;
        logic               masked;
        int                 pick;
        int                 shown;
        pick = $urandom_range(0, 99);
        masked = 1'($urandom_range(0, 1));
        it.data_byte = 8'($urandom);
        it.resync = lead_resync || ($urandom_range(0, 3) == 0);
        stream_q.push_back(it);
        it.resync = 1'b0;
        if (pick < 65)
        begin
            len = (pick < 55) ? 64'($urandom_range(0, 20)) : 64'($urandom_range(0, 125));
            it.data_byte = {masked, len[6:0]};
            stream_q.push_back(it);
        end
        else if (pick < 85)
        begin
            len = (pick < 80) ? 64'($urandom_range(0, 40)) : {48'd0, 16'($urandom)};
            it.data_byte = {masked, wsdf_pkg::LEN7_EXT16};
            stream_q.push_back(it);
            for (int i = 1; i >= 0; i--)
            begin
                it.data_byte = len[8 * i +: 8];
                stream_q.push_back(it);
            end
        end
        else
        begin
            len = (pick < 92) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
            it.data_byte = {masked, wsdf_pkg::LEN7_EXT64};
            stream_q.push_back(it);
            for (int i = 7; i >= 0; i--)
            begin
                it.data_byte = len[8 * i +: 8];
                stream_q.push_back(it);
            end
        end
        if (masked)
        begin
            repeat (4)
            begin
                it.data_byte = 8'($urandom);
                stream_q.push_back(it);
            end
        end
        if (len > 64'd60 || $urandom_range(0, 99) < 5)
        begin
            shown = (len > 64'd20) ? $urandom_range(0, 20) : $urandom_range(0, int'(len));
            cut = 1'b1;
        end
        else
        begin
            shown = int'(len);
            cut = 1'b0;
        end
        repeat (shown)
        begin
            it.data_byte = 8'($urandom);
            stream_q.push_back(it);
        end
    endtask

    initial
    begin : receiver
        int   run_left;
        int   p;
        out_stall = 1'b0;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                run_left = 0;
                out_stall <= 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 65)
                begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(0, 7);
                end
                else if (p < 95)
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run_left = $urandom_range(9, 39);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        wsdf_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected transfer on the output: %0h", out_data);
                errors++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (out_data.byte_kind !== want.byte_kind)
                begin
                    $error("byte_kind: expected %0h, got %0h",
                           want.byte_kind, out_data.byte_kind);
                    errors++;
                end
                if (out_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h",
                           want.out_byte, out_data.out_byte);
                    errors++;
                end
                if (out_data.fin_flag !== want.fin_flag)
                begin
                    $error("fin_flag: expected %0h, got %0h",
                           want.fin_flag, out_data.fin_flag);
                    errors++;
                end
                if (out_data.frame_opcode !== want.frame_opcode)
                begin
                    $error("frame_opcode: expected %0h, got %0h",
                           want.frame_opcode, out_data.frame_opcode);
                    errors++;
                end
                if (out_data.is_masked !== want.is_masked)
                begin
                    $error("is_masked: expected %0h, got %0h",
                           want.is_masked, out_data.is_masked);
                    errors++;
                end
                if (out_data.payload_length !== want.payload_length)
                begin
                    $error("payload_length: expected %0h, got %0h",
                           want.payload_length, out_data.payload_length);
                    errors++;
                end
                if (out_data.header_done !== want.header_done)
                begin
                    $error("header_done: expected %0h, got %0h",
                           want.header_done, out_data.header_done);
                    errors++;
                end
                if (out_data.frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0h, got %0h",
                           want.frame_end, out_data.frame_end);
                    errors++;
                end
                if (out_data.oversize !== want.oversize)
                begin
                    $error("oversize: expected %0h, got %0h",
                           want.oversize, out_data.oversize);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic                           cut;
        logic                           next_cut;
        logic                           paused;
        logic [wsdf_pkg::MAX_LEN_W-1:0] cfg_value;
        wsdf_pkg::in_item_t             it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write_enable = 1'b0;
        cfg_write_data = '0;
        hold_req = 1'b0;
        calm = 1'b0;
        errors = 0;
        phase_items = 0;
        idle_cycles = 0;
        ps_phase = PARSE_FIRST;
        ps_count = '0;
        ps_fin = 1'b0;
        ps_opcode = '0;
        ps_mask = 1'b0;
        ps_len = '0;
        ps_key = '0;
        ps_remaining = '0;
        ps_lane = '0;
        max_len = '1;

        directed_rows = '{
            '{'{8'h81, 1'b0}, 1'b1, header_result(1'b1, 4'h1, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h00, 1'b0}, 1'b1, header_result(1'b1, 4'h1, 1'b0, '0, 1'b1, 1'b1, 1'b0)},
            '{'{8'h02, 1'b0}, 1'b1, header_result(1'b0, 4'h2, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h7e, 1'b0}, 1'b1, header_result(1'b0, 4'h2, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h00, 1'b0}, 1'b1, header_result(1'b0, 4'h2, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h00, 1'b0}, 1'b1, header_result(1'b0, 4'h2, 1'b0, '0, 1'b1, 1'b1, 1'b0)},
            '{'{8'hff, 1'b0}, 1'b1, header_result(1'b1, 4'hf, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h7f, 1'b0}, 1'b1, header_result(1'b1, 4'hf, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h80, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b0, '0},
            '{'{8'haa, 1'b0}, 1'b0, '0},
            '{'{8'h88, 1'b1}, 1'b1, header_result(1'b1, 4'h8, 1'b0, '0, 1'b0, 1'b0, 1'b0)},
            '{'{8'h81, 1'b0}, 1'b1, header_result(1'b1, 4'h8, 1'b1, 63'd1, 1'b0, 1'b0, 1'b0)},
            '{'{8'h12, 1'b0}, 1'b0, '0},
            '{'{8'h34, 1'b0}, 1'b0, '0},
            '{'{8'h56, 1'b0}, 1'b0, '0},
            '{'{8'h78, 1'b0}, 1'b0, '0},
            '{'{8'hff, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0}, 1'b1, header_result(1'b0, 4'h0, 1'b0, '0, 1'b0, 1'b0, 1'b0)}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while (deframed_q.size() != 0);
            case (phase)
                0: cfg_value = '0;
                1: cfg_value = 63'd30;
                2: cfg_value = 63'({$urandom, $urandom});
                3: cfg_value = '1;
                4: cfg_value = 63'($urandom_range(0, 300));
                default: cfg_value = 63'($urandom_range(0, 65535));
            endcase
            cfg_write_enable <= 1'b1;
            cfg_write_data <= cfg_value;
            max_len = cfg_value;
            @(negedge clk);
            cfg_write_enable <= 1'b0;

            calm = (phase == 0);
            if (phase == 1)
                hold_req = 1'b1;
            phase_items = 0;
            cut = 1'b1;
            paused = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        it.data_byte = 8'($urandom);
                        it.resync = 1'($urandom_range(0, 1));
                        stream_q.push_back(it);
                    end
                    cut = 1'b1;
                end
                else
                begin
                    build_frame(cut, next_cut);
                    cut = next_cut;
                end
                while (stream_q.size() != 0)
                    send_byte(stream_q.pop_front(), 1'b0, '0);
                if (phase == 2 && !paused && phase_items >= 100)
                begin
                    paused = 1'b1;
                    in_valid <= 1'b0;
                    do
                        @(negedge clk);
                    while (deframed_q.size() != 0);
                end
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (deframed_q.size() != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_front.sv
rtl/core/wsdf_queue.sv
rtl/core/wsdf_back.sv
rtl/core/websocket_frame_deframer_top.sv
bench/testbench.sv
